// File: rtl/core/two_choice_double_hash_table_defines.svh
// ----------------------------------------------------------------------------
// two_choice_double_hash_table_defines
// Assertion macros for the hash table block.
// ----------------------------------------------------------------------------
`ifndef TWO_CHOICE_DOUBLE_HASH_TABLE_DEFINES_SVH
`define TWO_CHOICE_DOUBLE_HASH_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define TCH_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TCH_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TCH_ASSERT_IMP(label, clk, rst_n, a, c)
`define TCH_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: rtl/core/tch_pkg.sv
// ----------------------------------------------------------------------------
// tch_pkg
// Types and constants shared by the hash table block.
// ----------------------------------------------------------------------------
package tch_pkg;
    localparam int MAX_SLOTS = 1024;
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int LW = SW + 1;
    localparam int KW = 31;
    localparam int QDEPTH = 2;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DELETED   = 3'd5;
    localparam logic [2:0] ST_DEL_MISS  = 3'd6;

    localparam logic [10:0] LIMIT_RESET = 11'd11;

    // classified request handed from front to back
    typedef struct packed {
        logic [1:0]    action;
        logic [KW-1:0] key;
        logic [SW-1:0] h1;
        logic [SW-1:0] h2;
        logic [LW-1:0] p1;
        logic [LW-1:0] p2;
    } req_t;

    typedef struct packed {
        logic [2:0]    status;
        logic [SW-1:0] slot_index;
        logic [LW-1:0] key_count;
    } rsp_t;
endpackage

// File: rtl/core/tch_if.sv
// ----------------------------------------------------------------------------
// tch_req_if / tch_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tch_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [30:0] key;
    modport source (output valid, action, key, input ready);
    modport sink (input valid, action, key, output ready);
endinterface

interface tch_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [10:0] key_count;
    modport source (output valid, status, slot_index, key_count, input ready);
    modport sink (input valid, status, slot_index, key_count, output ready);
endinterface

// File: rtl/core/tch_front.sv
// ----------------------------------------------------------------------------
// tch_front
// Accepts a word, divides the key by the limit with a restoring divider and
// works out both home slots and probe steps.
// ----------------------------------------------------------------------------
module tch_front (
    input  logic                  clk,
    input  logic                  rst_n,
    tch_req_if.sink               req,
    input  logic [10:0]           limit,
    output logic                  out_valid,
    output tch_pkg::req_t         out_req,
    input  logic                  out_ready
);
    import tch_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001, F_DIV1 = 5'b00010, F_DIV2 = 5'b00100,
        F_STEP = 5'b01000, F_DONE = 5'b10000
    } fstate_t;

    fstate_t       state_reg, state_next;
    logic [1:0]    act_reg;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] quo_reg, quo_next;
    logic [KW:0]   rem_reg, rem_next;
    logic [KW-1:0] dvd_reg, dvd_next;
    logic [LW-1:0] dvs_reg, dvs_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [SW-1:0] h1_reg, h1_next, h2_reg, h2_next;
    logic [LW-1:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [KW:0]   trial;
    logic [KW-1:0] dvd_shift;
    logic [KW:0]   rem_step;
    logic [KW-1:0] quo_step;

    assign req.ready = (state_reg == F_IDLE);
    assign out_valid = (state_reg == F_DONE);
    assign out_req = '{action: act_reg, key: key_reg, h1: h1_reg, h2: h2_reg,
                       p1: p1_reg, p2: p2_reg};

    // one quotient bit per cycle
    always_comb
    begin
        dvd_shift = dvd_reg << 1;
        trial = {rem_reg[KW-1:0], dvd_reg[KW-1]};
        if (trial >= {{(KW+1-LW){1'b0}}, dvs_reg})
        begin
            rem_step = trial - {{(KW+1-LW){1'b0}}, dvs_reg};
            quo_step = {quo_reg[KW-2:0], 1'b1};
        end
        else
        begin
            rem_step = trial;
            quo_step = {quo_reg[KW-2:0], 1'b0};
        end
        state_next = state_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        h1_next = h1_reg;
        h2_next = h2_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (req.valid)
                begin
                    dvd_next = req.key;
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = 5'(KW - 1);
                    dvs_next = limit;
                    state_next = F_DIV1;
                end
            end
            F_DIV1, F_DIV2, F_STEP:
            begin
                dvd_next = dvd_shift;
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = 5'(KW - 1);
                    priority case (state_reg)
                        F_DIV1:
                        begin
                            // key mod L, then (key div L) mod L
                            h1_next = rem_step[SW-1:0];
                            dvd_next = quo_step;
                            state_next = F_DIV2;
                        end
                        F_DIV2:
                        begin
                            h2_next = rem_step[SW-1:0];
                            dvd_next = {{(KW-SW){1'b0}}, h1_reg};
                            dvs_next = dvs_reg - LW'(1);
                            state_next = F_STEP;
                        end
                        default:
                        begin
                            p1_next = LW'(1) + rem_step[LW-1:0];
                            dvd_next = {{(KW-SW){1'b0}}, h2_reg};
                            state_next = F_DONE;
                        end
                    endcase
                end
            end
            F_DONE:
            begin
                if (out_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // h2 mod (L-1) is small: h2 < L so one compare and subtract
    logic [LW-1:0] h2m;
    always_comb
    begin
        h2m = ({1'b0, h2_reg} >= (dvs_reg)) ? ({1'b0, h2_reg} - dvs_reg)
                                            : {1'b0, h2_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && req.valid)
        begin
            act_reg <= req.action;
            key_reg <= req.key;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        h1_reg <= h1_next;
        h2_reg <= h2_next;
        p1_reg <= p1_next;
        p2_reg <= (state_reg == F_STEP) ? LW'(2) + h2m : p2_reg;
    end
endmodule

// File: rtl/core/tch_queue.sv
// ----------------------------------------------------------------------------
// tch_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module tch_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  tch_pkg::req_t in_req,
    output logic          in_ready,
    output logic          out_valid,
    output tch_pkg::req_t out_req,
    input  logic          out_ready
);
    import tch_pkg::*;
    req_t       mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_req;
    end
endmodule

// File: rtl/core/tch_back.sv
// ----------------------------------------------------------------------------
// tch_back
// Walks the probe sequence over the slot memory and commits the result.
// A clearing pass sweeps the memory after reset and after a limit write.
// ----------------------------------------------------------------------------
module tch_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic [10:0]   limit,
    input  logic          in_valid,
    input  tch_pkg::req_t in_req,
    output logic          in_ready,
    tch_rsp_if.source     rsp
);
    import tch_pkg::*;
    `include "two_choice_double_hash_table_defines.svh"

    typedef enum logic [6:0] {
        B_CLEAR = 7'b0000001, B_IDLE = 7'b0000010, B_RD = 7'b0000100,
        B_CHK   = 7'b0001000, B_ADV = 7'b0010000, B_OUT = 7'b0100000,
        B_WAIT  = 7'b1000000
    } bstate_t;

    logic [31:0]   mem [MAX_SLOTS];
    logic [31:0]   rd_reg;
    bstate_t       state_reg;
    logic [SW-1:0] clr_reg;
    req_t          r_reg;
    logic [SW-1:0] s1_reg, s2_reg, addr;
    logic          side_reg, f1_reg, f2_reg, home_reg;
    logic [LW-1:0] cnt_reg;
    logic [2:0]    st_reg;
    logic [SW-1:0] slot_reg;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          hit, empty, place;
    logic [LW:0]   n1, n2;
    logic [SW-1:0] a1, a2;

    assign addr = side_reg ? s2_reg : s1_reg;
    assign hit = (rd_reg == {1'b1, r_reg.key});
    assign empty = !rd_reg[31];
    assign place = (r_reg.action == ACT_INSERT);
    assign in_ready = (state_reg == B_IDLE) && !clear;
    assign rsp.valid = (state_reg == B_OUT);
    assign rsp.status = st_reg;
    assign rsp.slot_index = slot_reg;
    assign rsp.key_count = cnt_reg;

    // wrap the next probe positions
    always_comb
    begin
        n1 = {2'b0, s1_reg} + {1'b0, r_reg.p1};
        n2 = {2'b0, s2_reg} + {1'b0, r_reg.p2};
        a1 = (n1 >= {1'b0, limit}) ? SW'(n1 - {1'b0, limit}) : n1[SW-1:0];
        a2 = (n2 >= {1'b0, limit}) ? SW'(n2 - {1'b0, limit}) : n2[SW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[addr];
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = addr;
        wr_data = '0;
        if (state_reg == B_CLEAR)
        begin
            wr_en = 1'b1;
            wr_addr = clr_reg;
        end
        else if (state_reg == B_CHK && hit && r_reg.action == ACT_DELETE)
            wr_en = 1'b1;
        else if (state_reg == B_CHK && place && empty && !hit)
        begin
            wr_en = 1'b1;
            wr_data = {1'b1, r_reg.key};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            state_reg <= B_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_reg <= clr_reg + SW'(1);
                    if (clr_reg == SW'(MAX_SLOTS - 1)) state_reg <= B_IDLE;
                end
                B_IDLE:
                begin
                    if (in_valid)
                    begin
                        r_reg <= in_req;
                        s1_reg <= in_req.h1;
                        s2_reg <= in_req.h2;
                        side_reg <= 1'b0;
                        f1_reg <= 1'b0;
                        f2_reg <= 1'b0;
                        home_reg <= 1'b1;
                        slot_reg <= '0;
                        if (in_req.action == ACT_INSERT && cnt_reg >= limit)
                        begin
                            st_reg <= ST_FULL;
                            state_reg <= B_OUT;
                        end
                        else if (in_req.action == ACT_DELETE && cnt_reg == '0)
                        begin
                            st_reg <= ST_DEL_MISS;
                            state_reg <= B_OUT;
                        end
                        else if (in_req.action == ACT_UNUSED)
                        begin
                            st_reg <= ST_NOT_FOUND;
                            state_reg <= B_OUT;
                        end
                        else
                            state_reg <= B_RD;
                    end
                end
                B_RD: state_reg <= B_CHK;
                B_CHK:
                begin
                    if (hit)
                    begin
                        slot_reg <= addr;
                        priority case (r_reg.action)
                            ACT_INSERT: st_reg <= ST_DUPLICATE;
                            ACT_SEARCH: st_reg <= ST_FOUND;
                            default:
                            begin
                                st_reg <= ST_DELETED;
                                cnt_reg <= cnt_reg - LW'(1);
                            end
                        endcase
                        state_reg <= B_OUT;
                    end
                    else if (place && empty)
                    begin
                        slot_reg <= addr;
                        st_reg <= ST_INSERTED;
                        cnt_reg <= cnt_reg + LW'(1);
                        state_reg <= B_OUT;
                    end
                    else if (!side_reg)
                    begin
                        side_reg <= 1'b1;
                        state_reg <= B_RD;
                    end
                    else if (!home_reg && f1_reg && f2_reg)
                    begin
                        priority case (r_reg.action)
                            ACT_INSERT: st_reg <= ST_FULL;
                            ACT_SEARCH: st_reg <= ST_NOT_FOUND;
                            default: st_reg <= ST_DEL_MISS;
                        endcase
                        state_reg <= B_OUT;
                    end
                    else
                        state_reg <= B_ADV;
                end
                B_ADV:
                begin
                    // advance both walks, mark a return home
                    s1_reg <= a1;
                    s2_reg <= a2;
                    if (a1 == r_reg.h1) f1_reg <= 1'b1;
                    if (a2 == r_reg.h2) f2_reg <= 1'b1;
                    home_reg <= 1'b0;
                    side_reg <= 1'b0;
                    state_reg <= B_RD;
                end
                B_OUT:
                begin
                    if (rsp.ready) state_reg <= B_WAIT;
                end
                B_WAIT: state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    `TCH_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= limit)
    `TCH_ASSERT_NXT(a_out_hold, clk, rst_n, rsp.valid && !rsp.ready && !clear,
        rsp.valid && $stable(st_reg))
    `TCH_ASSERT_IMP(a_ins_slot, clk, rst_n, rsp.valid && st_reg == ST_INSERTED,
        ({1'b0, slot_reg} < limit))
endmodule

// File: rtl/core/two_choice_double_hash_table.sv
// ----------------------------------------------------------------------------
// two_choice_double_hash_table
// Open-addressed hash table with two home slots and double-hash probe walks.
// ----------------------------------------------------------------------------
// channel  dir  fields
// req      in   action[1:0], key[30:0]
// rsp      out  status[2:0], slot_index[9:0], key_count[10:0]
// cfg      in   cfg_we, cfg_data[10:0] (table_limit)
//
// The front runs three divisions in turn (key mod L, key div L mod L,
// h1 mod L-1); the back then reads and checks each probed slot (B_RD,
// B_CHK), advances both walks in B_ADV and hands out the result through
// B_OUT and B_WAIT.
// A clearing pass over all 1024 slots follows reset and every limit write.
// The queue lets the front classify the next word while the back walks.
// ----------------------------------------------------------------------------
module two_choice_double_hash_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    tch_req_if.sink     req,
    tch_rsp_if.source   rsp
);
    import tch_pkg::*;

    logic [10:0] limit_reg;
    logic        fv, fr, qv, qr;
    req_t        freq, qreq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_we)
        begin
            // clamp to [2, MAX_SLOTS]
            if (cfg_data < 11'd2) limit_reg <= 11'd2;
            else if (cfg_data > 11'(MAX_SLOTS)) limit_reg <= 11'(MAX_SLOTS);
            else limit_reg <= cfg_data;
        end
    end

    tch_front u_front (.clk, .rst_n, .req, .limit(limit_reg),
        .out_valid(fv), .out_req(freq), .out_ready(fr));
    tch_queue u_queue (.clk, .rst_n, .in_valid(fv), .in_req(freq), .in_ready(fr),
        .out_valid(qv), .out_req(qreq), .out_ready(qr));
    tch_back u_back (.clk, .rst_n, .clear(cfg_we), .limit(limit_reg),
        .in_valid(qv), .in_req(qreq), .in_ready(qr), .rsp);
endmodule

// File: test/tch_result_checker.sv
// ----------------------------------------------------------------------------
// tch_result_checker
// Watches the request, result and register ports of the hash table, keeps
// its own copy of the table, and compares every result word with the one
// it predicted.
// ----------------------------------------------------------------------------
module tch_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    tch_req_if          req,
    tch_rsp_if          rsp,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          inserts_done,
    output int          fulls_seen
);
    import tch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]  table_mem [MAX_SLOTS];
    int unsigned  table_size;
    int unsigned  key_total;
    rsp_t         rsp_queue [$];

    function automatic int unsigned clamp_size(input logic [10:0] v);
        if (v < 2)
            return 2;
        if (v > MAX_SLOTS)
            return MAX_SLOTS;
        return 32'(v);
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < MAX_SLOTS; i++)
            table_mem[i] = '0;
        key_total = 0;
    endfunction

    // 1 = key found, 2 = free slot found (placing only), 0 = walks exhausted
    function automatic int probe_walk(input logic [KW-1:0] k, input bit placing,
                                      output int unsigned pos);
        int unsigned lim;
        int unsigned s [2];
        int unsigned home [2];
        int unsigned stride [2];
        bit          back [2];
        lim = table_size;
        s[0] = k % lim;
        s[1] = (k / lim) % lim;
        pos = 0;
        for (int w = 0; w < 2; w++)
        begin
            if (table_mem[s[w]] == {1'b1, k})
            begin
                pos = s[w];
                return 1;
            end
            if (placing && !table_mem[s[w]][31])
            begin
                pos = s[w];
                return 2;
            end
        end
        stride[0] = 1 + s[0] % (lim - 1);
        stride[1] = 2 + s[1] % (lim - 1);
        home[0] = s[0];
        home[1] = s[1];
        back[0] = 0;
        back[1] = 0;
        for (int n = 0; n <= lim; n++)
        begin
            for (int w = 0; w < 2; w++)
            begin
                s[w] = s[w] + stride[w];
                if (s[w] >= lim)
                    s[w] = s[w] - lim;
            end
            for (int w = 0; w < 2; w++)
            begin
                if (table_mem[s[w]] == {1'b1, k})
                begin
                    pos = s[w];
                    return 1;
                end
                if (placing && !table_mem[s[w]][31])
                begin
                    pos = s[w];
                    return 2;
                end
            end
            if (s[0] == home[0])
                back[0] = 1;
            if (s[1] == home[1])
                back[1] = 1;
            if (back[0] && back[1])
                break;
        end
        return 0;
    endfunction

    function automatic rsp_t apply_request(input logic [1:0] act,
                                           input logic [KW-1:0] k);
        rsp_t        r;
        int unsigned pos;
        int          hit;
        r.status = ST_NOT_FOUND;
        r.slot_index = '0;
        if (act == ACT_INSERT)
        begin
            if (key_total >= table_size)
                r.status = ST_FULL;
            else
            begin
                hit = probe_walk(k, 1, pos);
                if (hit == 1)
                begin
                    r.status = ST_DUPLICATE;
                    r.slot_index = SW'(pos);
                end
                else if (hit == 2)
                begin
                    table_mem[pos] = {1'b1, k};
                    key_total++;
                    r.status = ST_INSERTED;
                    r.slot_index = SW'(pos);
                end
                else
                    r.status = ST_FULL;
            end
        end
        else if (act == ACT_SEARCH)
        begin
            if (probe_walk(k, 0, pos) == 1)
            begin
                r.status = ST_FOUND;
                r.slot_index = SW'(pos);
            end
        end
        else if (act == ACT_DELETE)
        begin
            r.status = ST_DEL_MISS;
            if (key_total != 0 && probe_walk(k, 0, pos) == 1)
            begin
                table_mem[pos] = '0;
                key_total--;
                r.status = ST_DELETED;
                r.slot_index = SW'(pos);
            end
        end
        r.key_count = LW'(key_total);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            table_size = clamp_size(LIMIT_RESET);
            empty_table();
            rsp_queue.delete();
            errors = 0;
            pending = 0;
            results_seen = 0;
            inserts_done = 0;
            fulls_seen = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_size = clamp_size(cfg_data);
                empty_table();
            end
            if (req.valid && req.ready)
                rsp_queue.push_back(apply_request(req.action, req.key));
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (rsp.status == ST_INSERTED)
                    inserts_done++;
                if (rsp.status == ST_FULL)
                    fulls_seen++;
                if (rsp_queue.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result word with nothing pending: %s %0d %0d %0d",
                                 "status/slot/count", rsp.status, rsp.slot_index,
                                 rsp.key_count);
                end
                else
                begin
                    want = rsp_queue.pop_front();
                    if (rsp.status !== want.status ||
                        rsp.slot_index !== want.slot_index ||
                        rsp.key_count !== want.key_count)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: result %0d: expected status %0d slot %0d ",
                                      "count %0d, got status %0d slot %0d count %0d"},
                                     results_seen, want.status, want.slot_index,
                                     want.key_count, rsp.status, rsp.slot_index,
                                     rsp.key_count);
                    end
                end
            end
            pending = rsp_queue.size();
        end
    end
endmodule

// File: test/tb_two_choice_double_hash_table.sv
// ----------------------------------------------------------------------------
// tb_two_choice_double_hash_table
// Drives insert, search and delete requests into the hash table across a
// range of table limits and idle patterns; the checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_two_choice_double_hash_table;
    import tch_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;

    int          errors;
    int          pending;
    int          results_seen;
    int          inserts_done;
    int          fulls_seen;

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          squeeze_go;
    int          words_sent;
    int          limits_used;
    int unsigned cur_size;
    logic [KW-1:0] key_pool [64];

    tch_req_if req ();
    tch_rsp_if rsp ();

    two_choice_double_hash_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .rsp      (rsp)
    );

    tch_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .req          (req),
        .rsp          (rsp),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen),
        .inserts_done (inserts_done),
        .fulls_seen   (fulls_seen)
    );

    initial
        clk = 0;
    always #4 clk = ~clk;

    initial
    begin
        #50ms;
        $display("TIMEOUT waiting for the block");
        $display("tb_two_choice_double_hash_table failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        rsp.ready = 0;
        forever
        begin
            @(posedge clk);
            if (squeeze_go)
            begin
                rsp.ready <= 0;
                for (int c = 0; c < 600; c++)
                    @(posedge clk);
                squeeze_go = 0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // leaves valid high after acceptance; lowered only when a gap is taken
    task automatic send_word(input logic [1:0] act, input logic [KW-1:0] k);
        bit taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req.valid <= 1;
        req.action <= act;
        req.key <= k;
        do
        begin
            @(negedge clk);
            taken = req.ready;
            @(posedge clk);
        end
        while (!taken);
        words_sent++;
    endtask

    task automatic drain();
        req.valid <= 0;
        while (pending != 0)
            @(posedge clk);
        for (int c = 0; c < 300; c++)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [10:0] v);
        cfg_we <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        cur_size = (v < 2) ? 2 : ((v > MAX_SLOTS) ? MAX_SLOTS : v);
        limits_used++;
    endtask

    function automatic logic [KW-1:0] pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return key_pool[$urandom_range(63)];
        else if (sel < 80)
            return KW'($urandom_range(4 * cur_size * cur_size));
        else
            return KW'($urandom());
    endfunction

    task automatic random_run(input int count, input int mode);
        int sel;
        logic [1:0] act;
        send_idle_pct = (mode == 1) ? 62 : ((mode == 3) ? 24 : 0);
        recv_stall_pct = (mode == 2) ? 62 : ((mode == 3) ? 24 : 0);
        for (int i = 0; i < 64; i++)
            key_pool[i] = (i == 0) ? '0 : ((i == 1) ? '1 : KW'($urandom()));
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            act = (sel < 45) ? ACT_INSERT : (sel < 70) ? ACT_SEARCH :
                  (sel < 95) ? ACT_DELETE : ACT_UNUSED;
            send_word(act, pick_key());
        end
        drain();
    endtask

    initial
    begin
        req.valid = 0;
        req.action = ACT_INSERT;
        req.key = '0;
        cfg_we = 0;
        cfg_data = LIMIT_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        squeeze_go = 0;
        words_sent = 0;
        limits_used = 1;
        cur_size = LIMIT_RESET;
        rst_n = 0;
        for (int c = 0; c < 6; c++)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty delete, unused action, extremes, duplicate, fill to full
        send_word(ACT_DELETE, 31'd7);
        send_word(ACT_UNUSED, 31'd5);
        send_word(ACT_INSERT, 31'd0);
        send_word(ACT_INSERT, 31'h7FFF_FFFF);
        send_word(ACT_INSERT, 31'd0);
        send_word(ACT_SEARCH, 31'h7FFF_FFFF);
        send_word(ACT_SEARCH, 31'd12);
        send_word(ACT_DELETE, 31'd0);
        send_word(ACT_DELETE, 31'd0);
        for (int i = 1; i <= 10; i++)
            send_word(ACT_INSERT, 31'(i * 11 + 3));
        send_word(ACT_INSERT, 31'd99);
        send_word(ACT_SEARCH, 31'd25);
        drain();

        random_run(150, 0);
        write_limit(11'd2);
        random_run(100, 1);
        write_limit(11'd0);
        random_run(60, 2);
        write_limit(11'd1);
        random_run(60, 3);
        write_limit(11'd7);
        random_run(150, 1);

        // long receiver hold-off while the sender keeps offering
        write_limit(11'd64);
        squeeze_go = 1;
        random_run(250, 3);

        write_limit(11'd1024);
        random_run(50, 0);
        write_limit(11'd2047);
        random_run(40, 2);
        write_limit(11'd13);
        random_run(250, 2);
        write_limit(11'd11);
        random_run(100, 0);

        $display("Sent %0d request words over %0d table limits (2 to 1024, clamped values too)",
                 words_sent, limits_used);
        $display("Checked %0d result words: %0d inserts, %0d full rejects",
                 results_seen, inserts_done, fulls_seen);
        if (errors == 0)
            $display("tb_two_choice_double_hash_table passed");
        else
            $display("tb_two_choice_double_hash_table failed");
        $finish;
    end
endmodule
